// ===== sv/pfa_pkg.sv =====
// Shared types and constants of the paged frame allocator.
// No dependencies; pfa_ring, the core and the testbench refer to it by scoped names.
`default_nettype none

package pfa_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;

  localparam logic [4:0] PAGES_RESET = 5'd4;
  localparam int FRAMES_RESET = 256;

  typedef logic [2:0] status_t;

  localparam status_t STAT_GRANTED = 3'd0;
  localparam status_t STAT_RESIDENT = 3'd1;
  localparam status_t STAT_NO_ROOM = 3'd2;
  localparam status_t STAT_RELEASED = 3'd3;
  localparam status_t STAT_NOT_RESIDENT = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_LOOK,
    S_ONE,
    S_ARD,
    S_AWR,
    S_DRD,
    S_DWR
  } state_t;

  typedef struct packed {
    logic rd_req;
    logic pop;
    logic push;
    logic rebuild;
  } ring_ctl_t;

endpackage

`default_nettype wire

// ===== sv/pfa_if.sv =====
// Handshake interfaces of the request and result channels.
// Depends on nothing; used by the top level of the allocator.
`default_nettype none

interface pfa_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [5:0] process_id;

  modport source(output valid, output func, output process_id, input ready);
  modport sink(input valid, input func, input process_id, output ready);
endinterface

interface pfa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] frame;
  logic [3:0] page_index;
  logic       last;

  modport source(output valid, output status, output frame, output page_index,
                 output last, input ready);
  modport sink(input valid, input status, input frame, input page_index,
               input last, output ready);
endinterface

`default_nettype wire

// ===== sv/pfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pfa_ring.sv =====
// Free-frame ring: frame RAM plus head, tail, free count and fill tracking.
// Depends on pfa_pkg and pfa_ram.
`default_nettype none

module pfa_ring #(
  parameter int MAX_FRAMES = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire pfa_pkg::ring_ctl_t                   ctl,
  input  wire logic [pfa_pkg::CFG_DATA_W-1:0]       num_frames,
  input  wire logic [$clog2(MAX_FRAMES)-1:0]        push_frame,
  output logic      [$clog2(MAX_FRAMES)-1:0]        rd_frame,
  output logic      [$clog2(MAX_FRAMES+1)-1:0]      free_count
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int RST_NF = (pfa_pkg::FRAMES_RESET > MAX_FRAMES) ? MAX_FRAMES :
                          pfa_pkg::FRAMES_RESET;
  localparam logic [FW-1:0] RST_TAIL = (RST_NF == MAX_FRAMES) ? '0 : FW'(RST_NF);

  logic [FW-1:0]  head_r, head_nxt;
  logic [FW-1:0]  tail_r, tail_nxt;
  logic [FW-1:0]  tail0_r, tail0_nxt;
  logic [FCW-1:0] wcnt_r, wcnt_nxt;
  logic [FCW-1:0] free_r, free_nxt;
  logic [FW-1:0]  rd_addr_r;
  logic           rd_def_r;
  logic [FW-1:0]  ram_q;
  logic [FCW-1:0] nf_c;
  logic [31:0]    head_ofs;

  always_comb begin
    if (32'(num_frames) > MAX_FRAMES) begin
      nf_c = FCW'(MAX_FRAMES);
    end else begin
      nf_c = FCW'(num_frames);
    end
    if (head_r >= tail0_r) begin
      head_ofs = 32'(head_r) - 32'(tail0_r);
    end else begin
      head_ofs = 32'(head_r) + MAX_FRAMES - 32'(tail0_r);
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    tail0_nxt = tail0_r;
    wcnt_nxt = wcnt_r;
    free_nxt = free_r;
    if (ctl.rebuild) begin
      head_nxt = '0;
      if (32'(nf_c) == MAX_FRAMES) begin
        tail_nxt = '0;
      end else begin
        tail_nxt = FW'(nf_c);
      end
      tail0_nxt = tail_nxt;
      wcnt_nxt = '0;
      free_nxt = nf_c;
    end else begin
      if (ctl.pop) begin
        head_nxt = (32'(head_r) == MAX_FRAMES - 1) ? '0 : head_r + 1'b1;
        free_nxt = free_r - 1'b1;
      end
      if (ctl.push) begin
        tail_nxt = (32'(tail_r) == MAX_FRAMES - 1) ? '0 : tail_r + 1'b1;
        if (32'(wcnt_r) < MAX_FRAMES) begin
          wcnt_nxt = wcnt_r + 1'b1;
        end
        if (32'(free_r) < MAX_FRAMES) begin
          free_nxt = free_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= RST_TAIL;
      tail0_r <= RST_TAIL;
      wcnt_r <= '0;
      free_r <= FCW'(RST_NF);
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      tail0_r <= tail0_nxt;
      wcnt_r <= wcnt_nxt;
      free_r <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_req) begin
      rd_addr_r <= head_r;
      rd_def_r <= head_ofs < 32'(wcnt_r);
    end
  end

  pfa_ram #(
    .WIDTH(FW),
    .DEPTH(MAX_FRAMES)
  ) u_ring_ram (
    .clk  (clk),
    .we   (ctl.push),
    .waddr(tail_r),
    .wdata(push_frame),
    .re   (ctl.rd_req),
    .raddr(head_r),
    .rdata(ram_q)
  );

  // Entries never written since the last rebuild still hold their own index.
  assign rd_frame = rd_def_r ? ram_q : rd_addr_r;
  assign free_count = free_r;

endmodule

`default_nettype wire

// ===== sv/paged_frame_allocator_core.sv =====
// Paged frame allocator: request sequencer, page tables and result register.
// Depends on pfa_pkg, pfa_if, pfa_ram and pfa_ring.
//
// Requests arrive on in_ch (func 0 allocate, 1 deallocate, process_id) and
// are taken one at a time: in_ch.ready is high only while no request is in
// progress. Each request yields one or more results on out_ch; last marks
// the final one. A granting allocate or a release walks the process's pages,
// each page through a memory read state (S_ARD or S_DRD), then a write state
// (S_AWR or S_DWR) that writes the table or ring and registers the result.
// A process id of MAX_PROCS or more is first reduced in S_MOD by repeated
// subtraction of MAX_PROCS. Results leave through one output register;
// while out_ch stalls, the walk waits in place and resumes once the register
// is taken. Reset (rst_n, sync, active low) restores 4 pages per process and
// the full frame ring in ascending order with no resident process; a write
// of num_frames on the cfg port rebuilds the ring and residency the same way.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce it.
`default_nettype none

module paged_frame_allocator_core #(
  parameter int MAX_FRAMES = 256,
  parameter int MAX_PAGES = 16,
  parameter int MAX_PROCS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  pfa_in_if.sink                                  in_ch,
  pfa_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int XW = $clog2(MAX_PROCS);
  localparam int TDEPTH = MAX_PROCS * MAX_PAGES;
  localparam int TAW = $clog2(TDEPTH);

  pfa_pkg::state_t    state_r, state_nxt;
  pfa_pkg::ring_ctl_t ring_ctl;

  logic [4:0]           ppp_r, ppp_nxt;
  logic                 func_r, func_nxt;
  logic [5:0]           pid_r, pid_nxt;
  logic [PCW-1:0]       need_r, need_nxt;
  logic [PCW-1:0]       cnt_r, cnt_nxt;
  logic [PW-1:0]        page_r, page_nxt;
  pfa_pkg::status_t     code_r, code_nxt;
  logic [MAX_PROCS-1:0] resident_r, resident_nxt;

  logic                 out_valid_r, out_valid_nxt;
  pfa_pkg::status_t     out_status_r, out_status_nxt;
  logic [7:0]           out_frame_r, out_frame_nxt;
  logic [3:0]           out_page_r, out_page_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [XW-1:0]        pidx;
  logic [TAW-1:0]       tbl_addr;
  logic                 tbl_we, tbl_re;
  logic [FW-1:0]        tbl_q;
  logic                 cnt_we, cnt_re;
  logic [PCW-1:0]       cnt_q;
  logic [FW-1:0]        ring_frame;
  logic [FCW-1:0]       free_count;
  logic                 ospace;
  logic                 page_last;
  logic                 rebuild;
  logic [PCW-1:0]       need_c;

  assign pidx = XW'(pid_r);
  assign tbl_addr = TAW'(32'(pidx) * MAX_PAGES + 32'(page_r));
  assign ospace = !out_valid_r || out_ch.ready;
  assign rebuild = cfg_we && (cfg_index == pfa_pkg::CFG_FRAMES);

  always_comb begin
    if (ppp_r == '0) begin
      need_c = PCW'(1);
    end else if (32'(ppp_r) > MAX_PAGES) begin
      need_c = PCW'(MAX_PAGES);
    end else begin
      need_c = PCW'(ppp_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    ppp_nxt = ppp_r;
    func_nxt = func_r;
    pid_nxt = pid_r;
    need_nxt = need_r;
    cnt_nxt = cnt_r;
    page_nxt = page_r;
    code_nxt = code_r;
    resident_nxt = resident_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_frame_nxt = out_frame_r;
    out_page_nxt = out_page_r;
    out_last_nxt = out_last_r;
    ring_ctl = '0;
    tbl_we = 1'b0;
    tbl_re = 1'b0;
    cnt_we = 1'b0;
    cnt_re = 1'b0;
    in_ch.ready = 1'b0;
    page_last = 1'b0;

    case (state_r)
      pfa_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          pid_nxt = in_ch.process_id;
          need_nxt = need_c;
          page_nxt = '0;
          state_nxt = pfa_pkg::S_MOD;
        end
      end
      pfa_pkg::S_MOD: begin
        if (32'(pid_r) < MAX_PROCS) begin
          cnt_re = 1'b1;
          state_nxt = pfa_pkg::S_LOOK;
        end else begin
          pid_nxt = pid_r - 6'(MAX_PROCS);
        end
      end
      pfa_pkg::S_LOOK: begin
        cnt_nxt = cnt_q;
        if (!func_r) begin
          if (resident_r[pidx]) begin
            code_nxt = pfa_pkg::STAT_RESIDENT;
            state_nxt = pfa_pkg::S_ONE;
          end else if (32'(free_count) < 32'(need_r)) begin
            code_nxt = pfa_pkg::STAT_NO_ROOM;
            state_nxt = pfa_pkg::S_ONE;
          end else begin
            state_nxt = pfa_pkg::S_ARD;
          end
        end else begin
          if (!resident_r[pidx] || cnt_q == '0) begin
            resident_nxt[pidx] = 1'b0;
            code_nxt = pfa_pkg::STAT_NOT_RESIDENT;
            state_nxt = pfa_pkg::S_ONE;
          end else begin
            state_nxt = pfa_pkg::S_DRD;
          end
        end
      end
      pfa_pkg::S_ONE: begin
        if (ospace) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = code_r;
          out_frame_nxt = '0;
          out_page_nxt = '0;
          out_last_nxt = 1'b1;
          state_nxt = pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_ARD: begin
        ring_ctl.rd_req = 1'b1;
        state_nxt = pfa_pkg::S_AWR;
      end
      pfa_pkg::S_AWR: begin
        page_last = (32'(page_r) + 1) == 32'(need_r);
        if (ospace) begin
          ring_ctl.pop = 1'b1;
          tbl_we = 1'b1;
          out_valid_nxt = 1'b1;
          out_status_nxt = pfa_pkg::STAT_GRANTED;
          out_frame_nxt = 8'(32'(ring_frame));
          out_page_nxt = 4'(32'(page_r));
          out_last_nxt = page_last;
          if (page_last) begin
            cnt_we = 1'b1;
            resident_nxt[pidx] = 1'b1;
            state_nxt = pfa_pkg::S_IDLE;
          end else begin
            page_nxt = page_r + 1'b1;
            state_nxt = pfa_pkg::S_ARD;
          end
        end
      end
      pfa_pkg::S_DRD: begin
        tbl_re = 1'b1;
        state_nxt = pfa_pkg::S_DWR;
      end
      pfa_pkg::S_DWR: begin
        page_last = (32'(page_r) + 1) == 32'(cnt_r);
        if (ospace) begin
          ring_ctl.push = 1'b1;
          out_valid_nxt = 1'b1;
          out_status_nxt = pfa_pkg::STAT_RELEASED;
          out_frame_nxt = 8'(32'(tbl_q));
          out_page_nxt = 4'(32'(page_r));
          out_last_nxt = page_last;
          if (page_last) begin
            resident_nxt[pidx] = 1'b0;
            state_nxt = pfa_pkg::S_IDLE;
          end else begin
            page_nxt = page_r + 1'b1;
            state_nxt = pfa_pkg::S_DRD;
          end
        end
      end
      default: begin
        state_nxt = pfa_pkg::S_IDLE;
      end
    endcase

    if (cfg_we && (cfg_index == pfa_pkg::CFG_PAGES)) begin
      ppp_nxt = cfg_wdata[4:0];
    end
    if (rebuild) begin
      resident_nxt = '0;
      ring_ctl.rebuild = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppp_r <= pfa_pkg::PAGES_RESET;
      resident_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ppp_r <= ppp_nxt;
      resident_r <= resident_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    pid_r <= pid_nxt;
    need_r <= need_nxt;
    cnt_r <= cnt_nxt;
    page_r <= page_nxt;
    code_r <= code_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r <= out_frame_nxt;
    out_page_r <= out_page_nxt;
    out_last_r <= out_last_nxt;
  end

  pfa_ring #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ring_ctl),
    .num_frames(cfg_wdata),
    .push_frame(tbl_q),
    .rd_frame  (ring_frame),
    .free_count(free_count)
  );

  pfa_ram #(
    .WIDTH(FW),
    .DEPTH(TDEPTH)
  ) u_frame_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_addr),
    .wdata(ring_frame),
    .re   (tbl_re),
    .raddr(tbl_addr),
    .rdata(tbl_q)
  );

  pfa_ram #(
    .WIDTH(PCW),
    .DEPTH(MAX_PROCS)
  ) u_page_count (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(pidx),
    .wdata(need_r),
    .re   (cnt_re),
    .raddr(pidx),
    .rdata(cnt_q)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.frame = out_frame_r;
  assign out_ch.page_index = out_page_r;
  assign out_ch.last = out_last_r;

endmodule

`default_nettype wire

// ===== sim/paged_frame_allocator_core_test.sv =====
// Self-checking testbench of paged_frame_allocator_core: directed and random requests.
// Depends on pfa_pkg, pfa_if and paged_frame_allocator_core; a frame ledger class predicts and checks every result.
`timescale 1ns / 100ps

module paged_frame_allocator_core_test;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;
  localparam int RING_DEPTH = 256;
  localparam int PAGE_LIMIT = 16;
  localparam int PROC_COUNT = 64;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    pfa_pkg::status_t status;
    logic [7:0]       frame;
    logic [3:0]       page_index;
    logic             last;
  } frame_result_t;

  class frame_ledger;
    logic [7:0] free_ring [RING_DEPTH];
    logic [7:0] page_frame [PROC_COUNT][PAGE_LIMIT];
    int unsigned held [PROC_COUNT];
    bit resident [PROC_COUNT];
    int unsigned ring_head;
    int unsigned ring_tail;
    int unsigned free_frames;
    int unsigned pages_reg;
    int unsigned frames_reg;
    frame_result_t due_results[$];
    int errors;

    function new();
      pages_reg = 32'(pfa_pkg::PAGES_RESET);
      frames_reg = pfa_pkg::FRAMES_RESET;
      errors = 0;
      rebuild();
    endfunction

    function void rebuild();
      int unsigned n;
      n = (frames_reg > RING_DEPTH) ? RING_DEPTH : frames_reg;
      for (int i = 0; i < RING_DEPTH; i++) free_ring[i] = i[7:0];
      for (int p = 0; p < PROC_COUNT; p++) begin
        held[p] = 0;
        resident[p] = 1'b0;
      end
      ring_head = 0;
      ring_tail = n % RING_DEPTH;
      free_frames = n;
    endfunction

    function void set_config(logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                             logic [pfa_pkg::CFG_DATA_W-1:0] data);
      if (idx == pfa_pkg::CFG_PAGES) begin
        pages_reg = 32'(data[4:0]);
      end else if (idx == pfa_pkg::CFG_FRAMES) begin
        frames_reg = 32'(data);
        rebuild();
      end
    endfunction

    function void add_result(pfa_pkg::status_t st, logic [7:0] fr, logic [3:0] pg,
                             logic last);
      frame_result_t r;
      r.status = st;
      r.frame = fr;
      r.page_index = pg;
      r.last = last;
      due_results.insert(due_results.size(), r);
    endfunction

    function void note_request(logic func, logic [5:0] pid);
      int unsigned need;
      int unsigned cnt;
      logic [7:0] fr;
      need = (pages_reg < 1) ? 1 : ((pages_reg > PAGE_LIMIT) ? PAGE_LIMIT : pages_reg);
      if (func == FUNC_ALLOC) begin
        if (resident[pid]) begin
          add_result(pfa_pkg::STAT_RESIDENT, 8'd0, 4'd0, 1'b1);
        end else if (free_frames < need) begin
          add_result(pfa_pkg::STAT_NO_ROOM, 8'd0, 4'd0, 1'b1);
        end else begin
          for (int i = 0; i < need; i++) begin
            fr = free_ring[ring_head];
            ring_head = (ring_head + 1) % RING_DEPTH;
            free_frames--;
            page_frame[pid][i] = fr;
            add_result(pfa_pkg::STAT_GRANTED, fr, i[3:0], (i + 1 == need));
          end
          held[pid] = need;
          resident[pid] = 1'b1;
        end
      end else begin
        cnt = held[pid];
        if (!resident[pid] || cnt == 0) begin
          add_result(pfa_pkg::STAT_NOT_RESIDENT, 8'd0, 4'd0, 1'b1);
        end else begin
          for (int i = 0; i < cnt; i++) begin
            fr = page_frame[pid][i];
            free_ring[ring_tail] = fr;
            ring_tail = (ring_tail + 1) % RING_DEPTH;
            if (free_frames < RING_DEPTH) free_frames++;
            add_result(pfa_pkg::STAT_RELEASED, fr, i[3:0], (i + 1 == cnt));
          end
        end
        resident[pid] = 1'b0;
        held[pid] = 0;
      end
    endfunction

    function void report(string name, int unsigned want, int unsigned got);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    function void check_result(pfa_pkg::status_t st, logic [7:0] fr, logic [3:0] pg,
                               logic last);
      frame_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, %s %0d frame %0d page %0d last %0d",
                   $time, "actual status", st, fr, pg, last);
        return;
      end
      want = due_results.pop_front();
      if (want.status !== st) report("status", want.status, st);
      if (want.frame !== fr) report("frame", want.frame, fr);
      if (want.page_index !== pg) report("page_index", want.page_index, pg);
      if (want.last !== last) report("last", want.last, last);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bit calm = 1'b0;
  bit hold_long = 1'b0;

  frame_ledger ledger;

  pfa_in_if in_ch ();
  pfa_out_if out_ch ();

  paged_frame_allocator_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic send_req(input logic func, input logic [5:0] pid);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.process_id <= pid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.note_request(func, pid);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[pfa_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_config(idx, data[pfa_pkg::CFG_DATA_W-1:0]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.check_result(out_ch.status, out_ch.frame, out_ch.page_index, out_ch.last);
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned pages_tab [7];
    int unsigned frames_tab [7];
    logic func;
    logic [5:0] pid;
    pages_tab = '{4, 16, 3, 1, 8, 0, 5};
    frames_tab = '{256, 256, 37, 5, 64, 0, 100};
    ledger = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= pfa_pkg::CFG_PAGES;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_ALLOC;
    in_ch.process_id <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(FUNC_ALLOC, 6'd0);
    send_req(FUNC_ALLOC, 6'd0);
    send_req(FUNC_FREE, 6'd0);
    send_req(FUNC_FREE, 6'd0);
    send_req(FUNC_ALLOC, 6'd63);
    send_req(FUNC_FREE, 6'd5);
    drain();
    write_cfg(pfa_pkg::CFG_PAGES, 16);
    send_req(FUNC_ALLOC, 6'd42);
    send_req(FUNC_FREE, 6'd63);
    send_req(FUNC_FREE, 6'd42);
    drain();
    write_cfg(pfa_pkg::CFG_PAGES, 0);
    send_req(FUNC_ALLOC, 6'd21);
    send_req(FUNC_FREE, 6'd21);
    drain();
    write_cfg(pfa_pkg::CFG_PAGES, 31);
    send_req(FUNC_ALLOC, 6'd1);
    drain();
    write_cfg(pfa_pkg::CFG_FRAMES, 20);
    send_req(FUNC_ALLOC, 6'd1);
    send_req(FUNC_ALLOC, 6'd2);
    send_req(FUNC_FREE, 6'd1);
    send_req(FUNC_ALLOC, 6'd2);
    drain();
    write_cfg(pfa_pkg::CFG_FRAMES, 0);
    send_req(FUNC_ALLOC, 6'd3);
    send_req(FUNC_FREE, 6'd3);
    drain();
    write_cfg(pfa_pkg::CFG_FRAMES, 511);
    write_cfg(pfa_pkg::CFG_PAGES, 17);
    send_req(FUNC_ALLOC, 6'd0);
    drain();
    write_cfg(pfa_pkg::CFG_FRAMES, 1);
    write_cfg(pfa_pkg::CFG_PAGES, 1);
    send_req(FUNC_ALLOC, 6'd10);
    send_req(FUNC_ALLOC, 6'd11);
    send_req(FUNC_FREE, 6'd10);
    send_req(FUNC_ALLOC, 6'd11);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      if (ph == 5) begin
        pages_tab[ph] = $urandom_range(0, 31);
        frames_tab[ph] = $urandom_range(0, 511);
      end
      if (ph == 6) calm = 1'b1;
      write_cfg(pfa_pkg::CFG_PAGES, pages_tab[ph]);
      write_cfg(pfa_pkg::CFG_FRAMES, frames_tab[ph]);
      for (int n = 0; n < 40; n++) begin
        if (ph == 1 && n == 5) hold_long = 1'b1;
        if (ph == 2 && n == 20) drain();
        func = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) pid = 6'($urandom_range(0, 63));
        else pid = 6'($urandom_range(0, 9));
        send_req(func, pid);
      end
    end

    in_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pfa_pkg.sv
sv/pfa_if.sv
sv/pfa_ram.sv
sv/pfa_ring.sv
sv/paged_frame_allocator_core.sv
sim/paged_frame_allocator_core_test.sv
